// ----- rtl/spd_pkg.sv -----
// package with shared types and constants of the shortest path unit
`default_nettype none
package spd_pkg;
  localparam int unsigned DIST_BITS = 22;
  localparam int unsigned NODE_BITS = 6;
  localparam int unsigned RESULT_CAP = 64;
  localparam logic [DIST_BITS-1:0] DIST_MAX = 22'h3FFFFF;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_UNREACHABLE = 2'd1,
    ST_FULL        = 2'd2
  } status_t;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;
endpackage
`default_nettype wire

// ----- rtl/spd_node_ram.sv -----
// per-node record memory: distance, parent, reached and settled flags
`default_nettype none
module spd_node_ram import spd_pkg::*; #(
  parameter int unsigned NODES = 64,
  parameter int unsigned AW = 6,
  parameter int unsigned W = 30
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);
  logic [W-1:0] mem [NODES];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/shortest_path_dijkstra_unit.sv -----
// top level of the shortest path unit: edge table, node records and search sequencer
// add edge: result valid from S_OUT after the request is taken, via S_ADD2 with both_ways
// query: clear of all NODES records, then per settled node a min scan of all nodes and a relax
// pass over each stored edge with a record read per out-edge, one final empty scan, then the
// path walk per node plus output stalls; one request at a time, next after last result
// reset (rst, synchronous) empties the edge table and idles the sequencer;
// memories are not cleared, a query rewrites every node record before use
`default_nettype none
module shortest_path_dijkstra_unit import spd_pkg::*; #(
  parameter int unsigned NODES = 64,
  parameter int unsigned EDGES = 256,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // operation, edge_from, edge_to, edge_weight, both_ways, source_node, dest_node, pad
  input  wire logic [47:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // status, path_node, total_distance, pad
  output logic [31:0]      m_tdata,
  output logic             m_tlast
);
  localparam int unsigned NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned EW = $clog2(EDGES);
  localparam int unsigned CW = EW + 1;
  localparam int unsigned RW = DIST_BITS + NODE_BITS + 2;
  localparam int unsigned WB = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
  localparam int unsigned ERW = 2 * NODE_BITS + WB;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD2, S_OUT, S_CLEAR, S_SCAN, S_SCAN_END, S_BEST_RD, S_RELAX,
    S_RELAX_WAIT, S_WALK_RD, S_WALK, S_WALK_WAIT
  } state_t;

  state_t state;

  // request fields
  logic                   in_op, in_both;
  logic [NODE_BITS-1:0]   in_from, in_to, in_src, in_dst;
  logic [15:0]            in_weight;
  assign in_op     = s_tdata[0];
  assign in_from   = s_tdata[6:1];
  assign in_to     = s_tdata[12:7];
  assign in_weight = s_tdata[28:13];
  assign in_both   = s_tdata[29];
  assign in_src    = s_tdata[35:30];
  assign in_dst    = s_tdata[41:36];

  // edge table memory: {weight, to, from}
  logic [ERW-1:0] edge_mem [EDGES];
  logic           e_we;
  logic [EW-1:0]  e_waddr, e_raddr;
  logic [ERW-1:0] e_wdata, e_rdata;
  always_ff @(posedge clk) begin
    if (e_we) begin
      edge_mem[e_waddr] <= e_wdata;
    end
    e_rdata <= edge_mem[e_raddr];
  end

  // node record memory: {reached, settled, parent, distance}
  logic          n_we;
  logic [NW-1:0] n_waddr, n_raddr;
  logic [RW-1:0] n_wdata, n_rdata;
  spd_node_ram #(.NODES(NODES), .AW(NW), .W(RW)) u_nodes (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(n_raddr), .rdata(n_rdata)
  );
  logic                 r_reached, r_settled;
  logic [NODE_BITS-1:0] r_parent;
  logic [DIST_BITS-1:0] r_dist;
  assign {r_reached, r_settled, r_parent, r_dist} = n_rdata;

  // sequencer registers
  logic [CW-1:0]          edge_count;
  logic [NODE_BITS-1:0]   q_src, q_dst, pend_from, pend_to;
  logic [WB-1:0]          pend_w;
  logic [NW-1:0]          idx;
  logic [EW-1:0]          eidx;
  logic                   best_ok;
  logic [NW-1:0]          best;
  logic [DIST_BITS-1:0]   best_dist;
  logic [NODE_BITS-1:0]   best_par;
  logic                   scan_ok;
  logic [NW-1:0]          scan_node;
  logic [NW-1:0]          rx_to;
  logic [DIST_BITS-1:0]   rx_cand;
  logic [NODE_BITS-1:0]   cur;
  logic [DIST_BITS-1:0]   total;
  logic [6:0]             k;
  logic [1:0]             o_status;
  logic [NODE_BITS-1:0]   o_node;
  logic [DIST_BITS-1:0]   o_dist;
  logic                   o_last;

  assign s_tready = (state == S_IDLE) && !m_tvalid;
  assign m_tdata  = {2'b0, o_dist, o_node, o_status};
  assign m_tlast  = o_last;

  // candidate distance with saturation
  logic [DIST_BITS:0]   cand_sum;
  logic [DIST_BITS-1:0] cand;
  assign cand_sum = {1'b0, best_dist} + (DIST_BITS+1)'(e_rdata[ERW-1 -: WB]);
  assign cand = cand_sum[DIST_BITS] ? DIST_MAX : cand_sum[DIST_BITS-1:0];

  // edge read out leaves the settled node toward a valid node
  logic edge_hit;
  assign edge_hit = (e_rdata[NODE_BITS-1:0] == NODE_BITS'(best))
                 && (32'(e_rdata[2*NODE_BITS-1:NODE_BITS]) < NODES);

  // relax decision on the target record read for the pending edge
  logic rx_ok_wr, rx_settled_keep;
  assign rx_ok_wr = !r_reached || (rx_cand < r_dist);
  assign rx_settled_keep = r_reached && r_settled;

  // last stored edge of the relax pass
  logic last_edge;
  assign last_edge = (32'(eidx) + 32'd1 == 32'(edge_count));

  // memory port control
  always_comb begin
    e_we = 1'b0;
    e_waddr = edge_count[EW-1:0];
    e_wdata = {pend_w, pend_from, pend_to};
    e_raddr = eidx;
    n_we = 1'b0;
    n_waddr = idx;
    n_wdata = '0;
    n_raddr = idx;
    case (state)
      S_IDLE: begin
        if (s_tvalid && s_tready && in_op == OP_ADD
            && 32'(edge_count) + (in_both ? 32'd2 : 32'd1) <= EDGES) begin
          e_we = 1'b1;
          e_wdata = {in_weight[WB-1:0], in_to, in_from};
        end
      end
      S_ADD2: begin
        e_we = 1'b1;
      end
      S_CLEAR: begin
        n_we = 1'b1;
        n_wdata = (idx == NW'(q_src))
                ? {1'b1, 1'b0, q_src, {DIST_BITS{1'b0}}} : '0;
      end
      S_BEST_RD: begin
        e_raddr = '0;
        if (best_ok) begin
          n_we = 1'b1;
          n_waddr = best;
          n_wdata = {1'b1, 1'b1, best_par, best_dist};
        end
      end
      S_RELAX: begin
        e_raddr = eidx + 1'b1;
        n_raddr = NW'(e_rdata[2*NODE_BITS-1:NODE_BITS]);
      end
      S_RELAX_WAIT: begin
        e_raddr = eidx + 1'b1;
        if (rx_ok_wr) begin
          n_we = 1'b1;
          n_waddr = rx_to;
          n_wdata = {1'b1, rx_settled_keep, NODE_BITS'(best), rx_cand};
        end
      end
      S_WALK_RD: n_raddr = NW'(cur);
      default: ;
    endcase
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      edge_count <= '0;
      m_tvalid <= 1'b0;
      o_last <= 1'b0;
      scan_ok <= 1'b0;
      best_ok <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            if (in_op == OP_ADD) begin
              pend_from <= in_from;
              pend_to <= in_to;
              pend_w <= in_weight[WB-1:0];
              o_node <= '0;
              o_dist <= '0;
              o_last <= 1'b1;
              if (32'(edge_count) + (in_both ? 32'd2 : 32'd1) > EDGES) begin
                o_status <= ST_FULL;
                state <= S_OUT;
              end else begin
                o_status <= ST_OK;
                edge_count <= edge_count + 1'b1;
                state <= in_both ? S_ADD2 : S_OUT;
              end
            end else begin
              q_src <= in_src;
              q_dst <= in_dst;
              idx <= '0;
              if (32'(in_src) >= NODES || 32'(in_dst) >= NODES) begin
                o_status <= ST_UNREACHABLE;
                o_node <= in_dst;
                o_dist <= '0;
                o_last <= 1'b1;
                state <= S_OUT;
              end else begin
                state <= S_CLEAR;
              end
            end
          end
        end
        S_ADD2: begin
          edge_count <= edge_count + 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          m_tvalid <= 1'b1;
          state <= S_IDLE;
        end
        S_CLEAR: begin
          if (32'(idx) == NODES - 1) begin
            idx <= '0;
            best_ok <= 1'b0;
            scan_ok <= 1'b0;
            state <= S_SCAN;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        // min scan: address idx issued, record of scan_node arrives next cycle
        S_SCAN, S_SCAN_END: begin
          if (scan_ok && r_reached && !r_settled
              && (!best_ok || r_dist < best_dist)) begin
            best_ok <= 1'b1;
            best <= scan_node;
            best_dist <= r_dist;
            best_par <= r_parent;
          end
          scan_node <= idx;
          if (state == S_SCAN_END) begin
            scan_ok <= 1'b0;
            state <= S_BEST_RD;
          end else begin
            scan_ok <= 1'b1;
            if (32'(idx) == NODES - 1) begin
              state <= S_SCAN_END;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        // mark best settled, edge 0 read issued
        S_BEST_RD: begin
          idx <= '0;
          eidx <= '0;
          if (!best_ok) begin
            cur <= q_dst;
            k <= '0;
            state <= S_WALK_RD;
          end else if (edge_count == '0) begin
            best_ok <= 1'b0;
            scan_ok <= 1'b0;
            state <= S_SCAN;
          end else begin
            state <= S_RELAX;
          end
        end
        // relax: edge eidx read out now, target record read on a hit
        S_RELAX: begin
          if (edge_hit) begin
            rx_to <= NW'(e_rdata[2*NODE_BITS-1:NODE_BITS]);
            rx_cand <= cand;
            state <= S_RELAX_WAIT;
          end else if (last_edge) begin
            best_ok <= 1'b0;
            scan_ok <= 1'b0;
            state <= S_SCAN;
          end else begin
            eidx <= eidx + 1'b1;
          end
        end
        // target record arrives, update written by the port control
        S_RELAX_WAIT: begin
          if (last_edge) begin
            best_ok <= 1'b0;
            scan_ok <= 1'b0;
            state <= S_SCAN;
          end else begin
            eidx <= eidx + 1'b1;
            state <= S_RELAX;
          end
        end
        S_WALK_RD: state <= S_WALK;
        S_WALK: begin
          if (k == '0) begin
            if (!r_reached) begin
              o_status <= ST_UNREACHABLE;
              o_node <= q_dst;
              o_dist <= '0;
              o_last <= 1'b1;
              m_tvalid <= 1'b1;
              state <= S_IDLE;
            end else begin
              total <= r_dist;
              o_status <= ST_OK;
              o_node <= cur;
              o_dist <= r_dist;
              o_last <= (cur == q_src);
              m_tvalid <= 1'b1;
              k <= 7'd1;
              cur <= r_parent;
              state <= (cur == q_src) ? S_IDLE : S_WALK_WAIT;
            end
          end else begin
            o_status <= ST_OK;
            o_node <= cur;
            o_dist <= total;
            o_last <= (cur == q_src) || (32'(k) == RESULT_CAP - 1);
            m_tvalid <= 1'b1;
            k <= k + 1'b1;
            cur <= r_parent;
            state <= ((cur == q_src) || (32'(k) == RESULT_CAP - 1)) ? S_IDLE : S_WALK_WAIT;
          end
        end
        S_WALK_WAIT: begin
          if (!m_tvalid || m_tready) begin
            state <= S_WALK_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // assertions
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(edge_count) <= EDGES) else $error("edge count beyond table");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_tready) else $error("request taken while busy");
  a_full_keeps: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && o_status == ST_FULL) |-> $stable(edge_count))
    else $error("full table changed");
endmodule
`default_nettype wire
